### hdl/bloom_filter_insert_lookup_defines.svh
// Assertion macros used by the port-level checker of the Bloom filter block.
`ifndef BLOOM_FILTER_INSERT_LOOKUP_DEFINES_SVH
`define BLOOM_FILTER_INSERT_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFIL_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFIL_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers reset itself.
`define BFIL_ASSERT_RST(label, ck, rs, cons, msg) \
  label: assert property (@(posedge ck) (rs) |=> (cons)) else $error(msg);

`endif

### hdl/bfil_pkg.sv
// Types and constants shared by the Bloom filter modules.
package bfil_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 21;
  localparam int NUM_BITS_W = 21;
  localparam int NUM_HASH_W = 6;
  localparam int CNT_W      = 7;
  localparam int DIV_CNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 8'd1;

  localparam logic [NUM_BITS_W-1:0] NUM_BITS_RST   = 21'd1048576;
  localparam logic [NUM_HASH_W-1:0] NUM_HASHES_RST = 6'd1;

  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_ADD  = 32'he6546b64;
  localparam logic [31:0] MM_FM1  = 32'h85ebca6b;
  localparam logic [31:0] MM_FM2  = 32'hc2b2ae35;
  localparam logic [31:0] MM_LEN  = 32'd8;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_K1A, S_K1B, S_H1, S_K2A, S_K2B, S_H2,
    S_F1, S_F2, S_F3, S_DIV, S_RD, S_CHK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_KA_LO, OP_KA_HI, OP_KB, OP_HMIX, OP_F1, OP_F2, OP_F3, OP_DIV
  } op_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    op_t  op;
    logic rd;
    logic chk;
    logic next_seed;
    logic hit_clr;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic k_zero;
    logic div_last;
    logic miss;
    logic seed_last;
  } sts_t;

endpackage

### hdl/bfil_ctrl.sv
// Controller state machine that sequences the clear sweep, hashing, reduction and bit access.
module bfil_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bfil_pkg::sts_t  sts,
  output bfil_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import bfil_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = sts.k_zero ? S_DONE : S_K1A;
      S_K1A:   state_next = S_K1B;
      S_K1B:   state_next = S_H1;
      S_H1:    state_next = S_K2A;
      S_K2A:   state_next = S_K2B;
      S_K2B:   state_next = S_H2;
      S_H2:    state_next = S_F1;
      S_F1:    state_next = S_F2;
      S_F2:    state_next = S_F3;
      S_F3:    state_next = S_DIV;
      S_DIV:   if (sts.div_last) state_next = S_RD;
      S_RD:    state_next = S_CHK;
      S_CHK:   state_next = (sts.miss || sts.seed_last) ? S_DONE : S_K1A;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clear_wr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_K1A:   cmd.op = OP_KA_LO;
      S_K1B:   cmd.op = OP_KB;
      S_H1:    cmd.op = OP_HMIX;
      S_K2A:   cmd.op = OP_KA_HI;
      S_K2B:   cmd.op = OP_KB;
      S_H2:    cmd.op = OP_HMIX;
      S_F1:    cmd.op = OP_F1;
      S_F2:    cmd.op = OP_F2;
      S_F3:    cmd.op = OP_F3;
      S_DIV:   cmd.op = OP_DIV;
      S_RD:    cmd.rd = 1'b1;
      S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.miss) begin
          cmd.hit_clr = 1'b1;
        end else if (!sts.seed_last) begin
          cmd.next_seed = 1'b1;
        end
      end
      S_DONE:  done = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/bfil_datapath.sv
// Datapath: configuration, MurmurHash3 unit, remainder unit and the bit store.
module bfil_datapath #(
  parameter int MAX_BITS   = 1048576,
  parameter int MAX_HASHES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [bfil_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfil_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           operation,
  input  logic [63:0]                    key,
  input  bfil_pkg::cmd_t                 cmd,
  output bfil_pkg::sts_t                 sts,
  output logic                           hit
);
  import bfil_pkg::*;

  localparam int ROWS   = MAX_BITS / 8;
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int M_W    = ($clog2(MAX_BITS + 1) > NUM_BITS_W) ? $clog2(MAX_BITS + 1)
                                                              : NUM_BITS_W;
  localparam int R_W    = M_W + 1;

  logic [NUM_BITS_W-1:0] num_bits;
  logic [NUM_HASH_W-1:0] num_hashes;
  logic [ADDR_W-1:0]     clr_addr;

  logic                  op_r;
  logic [63:0]           key_r;
  logic [31:0]           h;
  logic [31:0]           kk;
  logic [CNT_W-1:0]      seed;
  logic [31:0]           quo;
  logic [R_W-1:0]        rem;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic                  hit_r;
  logic [7:0]            rd_data;

  logic [7:0] mem [ROWS];

  logic [M_W-1:0]   m_eff;
  logic [M_W-1:0]   nb_ext;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] nh_ext;
  logic [31:0]      mul_a, mul_b, prod;
  logic [31:0]      f1, f2, f3, hm, hmix;
  logic [R_W-1:0]   r_new;
  logic [31:0]      q_new;
  logic [ADDR_W-1:0] row;
  logic [7:0]       mask;

  // Configuration registers; writes are always taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits   <= NUM_BITS_RST;
      num_hashes <= NUM_HASHES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_BITS:   num_bits   <= cfg_data;
        REG_NUM_HASHES: num_hashes <= cfg_data[NUM_HASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nb_ext = M_W'(num_bits);
    if (nb_ext == '0) begin
      m_eff = M_W'(1);
    end else if (nb_ext > M_W'(MAX_BITS)) begin
      m_eff = M_W'(MAX_BITS);
    end else begin
      m_eff = nb_ext;
    end
    nh_ext = CNT_W'(num_hashes);
    k_eff  = (nh_ext > CNT_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES) : nh_ext;
  end

  // Mixing terms of the hash.
  always_comb begin
    f1   = h ^ MM_LEN;
    f1   = f1 ^ (f1 >> 16);
    f2   = h ^ (h >> 13);
    f3   = h ^ (h >> 16);
    hm   = h ^ kk;
    hm   = {hm[18:0], hm[31:19]};
    hmix = (hm << 2) + hm + MM_ADD;
  end

  // One shared 32x32 multiplier; only the low word is kept.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_KA_LO: begin mul_a = key_r[31:0];          mul_b = MM_C1;  end
      OP_KA_HI: begin mul_a = key_r[63:32];         mul_b = MM_C1;  end
      OP_KB:    begin mul_a = {kk[16:0], kk[31:17]}; mul_b = MM_C2; end
      OP_F1:    begin mul_a = f1;                   mul_b = MM_FM1; end
      OP_F2:    begin mul_a = f2;                   mul_b = MM_FM2; end
      default:  begin mul_a = '0;                   mul_b = '0;     end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Restoring remainder, four dividend bits per cycle.
  always_comb begin
    logic [R_W-1:0] r_sh;
    r_new = rem;
    q_new = quo;
    for (int j = 0; j < 4; j++) begin
      r_sh  = {r_new[M_W-1:0], q_new[31]};
      q_new = q_new << 1;
      if (r_sh >= {1'b0, m_eff}) begin
        r_new = r_sh - {1'b0, m_eff};
      end else begin
        r_new = r_sh;
      end
    end
  end

  assign row  = rem[ADDR_W+2:3];
  assign mask = 8'd1 << rem[2:0];

  assign sts.clear_last = (clr_addr == ADDR_W'(ROWS - 1));
  assign sts.k_zero     = (k_eff == '0);
  assign sts.div_last   = (div_cnt == '1);
  assign sts.miss       = !op_r && !rd_data[rem[2:0]];
  assign sts.seed_last  = (CNT_W'(seed + CNT_W'(1)) == k_eff);
  assign hit            = hit_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      key_r <= key;
      seed  <= '0;
      hit_r <= 1'b1;
    end
    if (cmd.next_seed) begin
      seed <= seed + CNT_W'(1);
    end
    if (cmd.hit_clr) begin
      hit_r <= 1'b0;
    end
    unique case (cmd.op)
      OP_KA_LO: begin
        kk <= prod;
        h  <= 32'(seed);
      end
      OP_KA_HI, OP_KB: kk <= prod;
      OP_HMIX:         h  <= hmix;
      OP_F1, OP_F2:    h  <= prod;
      OP_F3: begin
        quo     <= f3;
        rem     <= '0;
        div_cnt <= '0;
      end
      OP_DIV: begin
        quo     <= q_new;
        rem     <= r_new;
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Bit store, one byte per row; clear sweep and read-modify-write share the port.
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[clr_addr] <= 8'd0;
    end else if (cmd.chk && op_r) begin
      mem[row] <= rd_data | mask;
    end
    if (cmd.rd) begin
      rd_data <= mem[row];
    end
  end

endmodule

### hdl/bloom_filter_insert_lookup.sv
// Top level of the Bloom filter with insert and lookup.
//
// Request channel: a request (operation, key) is taken on a clock edge where
// start is high and busy is low. Operation 1 inserts the key, 0 looks it up.
// Result: done is high for exactly one cycle with hit valid in that cycle;
// insert always answers 1, lookup answers 1 only if every hashed bit is set.
// The receiver cannot stall; one request is in flight at a time.
// Configuration: cfg_valid with cfg_index/cfg_data writes num_bits (index 0)
// or num_hashes (index 1); cfg_ready is always high. Write only while idle.
// Per hash: nine hash steps on one shared multiplier, eight remainder steps
// at four bits each, a memory read and a check or write. A lookup ends at
// the first clear bit. With no hashes done is high in the cycle right after
// the request. Busy drops in the cycle after done, and only then is the next
// request taken.
// Reset: a clearing pass writes all MAX_BITS/8 rows of the bit store one byte
// per cycle, with busy high; configuration writes are still taken then.
module bloom_filter_insert_lookup #(
  parameter int MAX_BITS   = 1048576,
  parameter int MAX_HASHES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           operation,
  input  logic [63:0]                    key,
  output logic                           busy,
  output logic                           done,
  output logic                           hit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfil_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfil_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfil_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfil_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bfil_datapath #(
    .MAX_BITS   (MAX_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (operation),
    .key       (key),
    .cmd       (cmd),
    .sts       (sts),
    .hit       (hit)
  );

endmodule

### hdl/bfil_checker.sv
// Port-level checker for the Bloom filter and its bind to the top level.
`include "bloom_filter_insert_lookup_defines.svh"

module bfil_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `BFIL_ASSERT_RST(a_reset_busy, clk, rst, busy, "block not busy after reset")
  `BFIL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken")
  `BFIL_ASSERT_IMP(a_done_busy, clk, rst, done, busy, "result while idle")
  `BFIL_ASSERT_NEXT(a_done_once, clk, rst, done, !done && !busy, "result repeated")

endmodule

bind bloom_filter_insert_lookup bfil_checker u_bfil_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
